>>> rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants
// Word formats, decoded queue entry and sizes for the step/dir generator.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int MotorCount = 3;
  localparam int TimeWidth  = 32;
  localparam int RegWidth   = 20;
  localparam int PosWidth   = 32;
  localparam int DelayWidth = 32;
  localparam int QDepth     = 2;
  localparam int QPtrWidth  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntWidth  = $clog2(QDepth + 1);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  localparam logic CFG_MIN_PERIOD = 1'b0;
  localparam logic CFG_MAX_PERIOD = 1'b1;

  localparam logic [RegWidth-1:0] MIN_PERIOD_RST  = RegWidth'(10);
  localparam logic [RegWidth-1:0] MAX_PERIOD_RST  = RegWidth'(1000000);
  localparam logic [RegWidth-1:0] HALF_PERIOD_RST = RegWidth'(1000);

  typedef struct packed {
    logic                         op;
    logic [TimeWidth-1:0]         now_us;
    logic signed [DelayWidth-1:0] delay_a;
    logic signed [DelayWidth-1:0] delay_b;
    logic signed [DelayWidth-1:0] delay_c;
  } in_word_t;

  typedef struct packed {
    logic                       step_out_a;
    logic                       step_out_b;
    logic                       step_out_c;
    logic                       dir_out_a;
    logic                       dir_out_b;
    logic                       dir_out_c;
    logic signed [PosWidth-1:0] pos_a;
    logic signed [PosWidth-1:0] pos_b;
    logic signed [PosWidth-1:0] pos_c;
    logic [MotorCount-1:0]      enable_mask;
  } out_word_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic                                 op;
    logic [TimeWidth-1:0]                 now_us;
    logic [MotorCount-1:0]                en;
    logic [MotorCount-1:0]                dir;
    logic [MotorCount-1:0][RegWidth-1:0]  period;
  } cmd_t;

  typedef struct packed {
    logic                 not_empty;
    logic                 full;
    logic [QCntWidth-1:0] count;
  } q_stat_t;

endpackage

>>> rtl/stp_front.sv
// ----------------------------------------------------------------------------
// stp_front: input classification
// Holds the period limits and decodes each word into per-motor enable,
// half period and direction, ready for the queue.
// ----------------------------------------------------------------------------
module stp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [stp_pkg::RegWidth-1:0]  cfg_wdata_i,
  input  stp_pkg::in_word_t             in_data_i,
  output stp_pkg::cmd_t                 cmd_o
);

  logic [stp_pkg::RegWidth-1:0]   min_q, min_d;
  logic [stp_pkg::RegWidth-1:0]   max_q, max_d;
  logic [stp_pkg::DelayWidth-1:0] dly [stp_pkg::MotorCount];
  logic [stp_pkg::DelayWidth-1:0] mag [stp_pkg::MotorCount];

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        stp_pkg::CFG_MIN_PERIOD: min_d = cfg_wdata_i;
        stp_pkg::CFG_MAX_PERIOD: max_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= stp_pkg::MIN_PERIOD_RST;
      max_q <= stp_pkg::MAX_PERIOD_RST;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign dly[0] = in_data_i.delay_a;
  assign dly[1] = in_data_i.delay_b;
  assign dly[2] = in_data_i.delay_c;

  // most negative delay has magnitude 2^31, always above the limit
  always_comb begin
    cmd_o.op     = in_data_i.op;
    cmd_o.now_us = in_data_i.now_us;
    for (int m = 0; m < stp_pkg::MotorCount; m++) begin
      mag[m] = dly[m][stp_pkg::DelayWidth-1] ? (~dly[m] + 1'b1) : dly[m];
      cmd_o.en[m] =
        (mag[m] >= {{(stp_pkg::DelayWidth-stp_pkg::RegWidth){1'b0}}, min_q}) &&
        (mag[m] <= {{(stp_pkg::DelayWidth-stp_pkg::RegWidth){1'b0}}, max_q});
      cmd_o.dir[m]    = !dly[m][stp_pkg::DelayWidth-1] && (mag[m] != '0);
      cmd_o.period[m] = mag[m][stp_pkg::RegWidth-1:0];
    end
  end

endmodule

>>> rtl/stp_queue.sv
// ----------------------------------------------------------------------------
// stp_queue: decoupling queue
// Short FIFO of classified words between the front and the motor engine.
// ----------------------------------------------------------------------------
module stp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stp_pkg::cmd_t     push_data_i,
  input  logic              pop_i,
  output stp_pkg::cmd_t     pop_data_o,
  output stp_pkg::q_stat_t  stat_o
);

  stp_pkg::cmd_t                   mem [stp_pkg::QDepth];
  logic [stp_pkg::QPtrWidth-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [stp_pkg::QCntWidth-1:0]   cnt_q, cnt_d;

  function automatic logic [stp_pkg::QPtrWidth-1:0] ptr_inc(
    input logic [stp_pkg::QPtrWidth-1:0] p
  );
    if (p == stp_pkg::QPtrWidth'(stp_pkg::QDepth - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= push_data_i;
    end
  end

  assign pop_data_o       = mem[rptr_q];
  assign stat_o.not_empty = (cnt_q != '0);
  assign stat_o.full      = (cnt_q == stp_pkg::QCntWidth'(stp_pkg::QDepth));
  assign stat_o.count     = cnt_q;

endmodule

>>> rtl/stp_back.sv
// ----------------------------------------------------------------------------
// stp_back: motor engine
// Applies commands and ticks to per-motor state and registers the result word.
// ----------------------------------------------------------------------------
module stp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  stp_pkg::cmd_t       q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stp_pkg::out_word_t  out_data_o
);

  localparam int MC = stp_pkg::MotorCount;

  logic [MC-1:0]                  step_q, step_d;
  logic [MC-1:0]                  cdir_q, cdir_d;
  logic [MC-1:0]                  dir_q, dir_d;
  logic [MC-1:0]                  en_q, en_d;
  logic [stp_pkg::RegWidth-1:0]   half_q [MC];
  logic [stp_pkg::RegWidth-1:0]   half_d [MC];
  logic [stp_pkg::TimeWidth-1:0]  last_q [MC];
  logic [stp_pkg::TimeWidth-1:0]  last_d [MC];
  logic [stp_pkg::PosWidth-1:0]   pos_q  [MC];
  logic [stp_pkg::PosWidth-1:0]   pos_d  [MC];
  logic [stp_pkg::TimeWidth-1:0]  elapsed [MC];
  logic                           out_valid_q, out_valid_d;
  stp_pkg::out_word_t             out_q, out_d;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    step_d = step_q;
    cdir_d = cdir_q;
    dir_d  = dir_q;
    en_d   = en_q;
    for (int m = 0; m < MC; m++) begin
      half_d[m]  = half_q[m];
      last_d[m]  = last_q[m];
      pos_d[m]   = pos_q[m];
      elapsed[m] = q_data_i.now_us - last_q[m];
      if (q_data_i.op == stp_pkg::OP_CMD) begin
        en_d[m] = q_data_i.en[m];
        if (q_data_i.en[m]) begin
          half_d[m] = q_data_i.period[m];
          cdir_d[m] = q_data_i.dir[m];
        end
      end else if (!en_q[m]) begin
        last_d[m] = q_data_i.now_us;
      end else if (elapsed[m] >=
                   {{(stp_pkg::TimeWidth-stp_pkg::RegWidth){1'b0}}, half_q[m]}) begin
        last_d[m] = q_data_i.now_us;
        step_d[m] = ~step_q[m];
        dir_d[m]  = cdir_q[m];
        // rising edge of the step line moves the position
        if (!step_q[m]) begin
          pos_d[m] = cdir_q[m] ? pos_q[m] + 1'b1 : pos_q[m] - 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_d.step_out_a  = step_d[0];
    out_d.step_out_b  = step_d[1];
    out_d.step_out_c  = step_d[2];
    out_d.dir_out_a   = dir_d[0];
    out_d.dir_out_b   = dir_d[1];
    out_d.dir_out_c   = dir_d[2];
    out_d.pos_a       = pos_d[0];
    out_d.pos_b       = pos_d[1];
    out_d.pos_c       = pos_d[2];
    out_d.enable_mask = en_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      cdir_q      <= '0;
      dir_q       <= '0;
      en_q        <= '0;
      out_valid_q <= 1'b0;
      for (int m = 0; m < MC; m++) begin
        half_q[m] <= stp_pkg::HALF_PERIOD_RST;
        last_q[m] <= '0;
        pos_q[m]  <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o) begin
        step_q <= step_d;
        cdir_q <= cdir_d;
        dir_q  <= dir_d;
        en_q   <= en_d;
        for (int m = 0; m < MC; m++) begin
          half_q[m] <= half_d[m];
          last_q[m] <= last_d[m];
          pos_q[m]  <= pos_d[m];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/three_axis_step_dir_generator_core.sv
// ----------------------------------------------------------------------------
// three_axis_step_dir_generator_core: three-motor step/dir pulse generator
// Front classifies words, a two-entry queue decouples it from the motor engine.
// ----------------------------------------------------------------------------
// Path: an accepted input word is written into the queue, then popped into the
//   output register when that register is free or is being read out.
// Throughput: one word per cycle while out_ready_i holds; each motor's state is registered on every pop.
// Reset: asynchronous; motors disabled, positions zero, half periods 1000,
//   limits back to 10 and 1000000.
module three_axis_step_dir_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [stp_pkg::RegWidth-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  stp_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output stp_pkg::out_word_t            out_data_o
);

  stp_pkg::cmd_t     front_cmd;
  stp_pkg::cmd_t     q_data;
  stp_pkg::q_stat_t  q_stat;
  logic              q_push;
  logic              q_pop;

  stp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_o       (front_cmd)
  );

  assign in_ready_o = !q_stat.full;
  assign q_push     = in_valid_i && in_ready_o;

  stp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (front_cmd),
    .pop_i       (q_pop),
    .pop_data_o  (q_data),
    .stat_o      (q_stat)
  );

  stp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_stat.not_empty),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.not_empty)
    else $error("queue popped while empty");

  a_word_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> (q_stat.not_empty || out_valid_o))
    else $error("accepted word lost between queue and output");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= stp_pkg::QCntWidth'(stp_pkg::QDepth))
    else $error("queue count over depth");

endmodule
